// ===== rtl/magnetometer_heading_calibration_macros.svh =====
// ----------------------------------------------------------------------------
// magnetometer heading calibration assertion macros
// concurrent check wrappers, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef MAGNETOMETER_HEADING_CALIBRATION_MACROS_SVH
`define MAGNETOMETER_HEADING_CALIBRATION_MACROS_SVH

`ifndef SYNTH
// check with clk as clock, disabled while rst_n is low
`define MHC_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mhc check failed");
// check with clk as clock, active during reset too
`define MHC_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("mhc reset check failed");
`else
`define MHC_ASSERT(label, prop)
`define MHC_ASSERT_RST(label, prop)
`endif

`endif

// ===== rtl/mhc_pkg.sv =====
// ----------------------------------------------------------------------------
// mhc_pkg
// shared widths, codes, types and the cordic angle table
// ----------------------------------------------------------------------------
package mhc_pkg;

  localparam int AXIS_W    = 16;
  localparam int DIFF_W    = AXIS_W + 1;
  localparam int HEADING_W = 15;
  localparam int OP_W      = 2;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 16;
  localparam int COUNT_W   = 10;

  // op codes
  localparam logic [OP_W-1:0] OP_MEASURE = 2'd0;
  localparam logic [OP_W-1:0] OP_START   = 2'd1;
  localparam logic [OP_W-1:0] OP_SAMPLE  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CAL_SAMPLES = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPAN_THR    = 4'd1;

  localparam logic [COUNT_W-1:0]  CAL_SAMPLES_RST = 10'd200;
  localparam logic [AXIS_W-1:0]   SPAN_THR_RST    = 16'd25;

  // parameter defaults
  localparam int ANGLE_FRAC_BITS_DEF = 6;
  localparam int CORDIC_STEPS_DEF    = 16;

  // cordic datapath
  localparam int PRESCALE_BITS = 8;
  localparam int CORDIC_XW     = 28;
  localparam int CORDIC_ZW     = 27;
  localparam int DEG_BITS      = 16;
  localparam int ATAN_LEN      = 24;
  localparam int ATAN_IDX_W    = 5;
  localparam int ATAN_W        = 22;

  typedef enum logic {
    ST_IDLE,
    ST_BUSY
  } state_t;

  typedef struct packed {
    logic clear;
    logic track;
    logic finish;
  } lane_ctrl_t;

  // atan(2^-i) in degrees, q16
  function automatic logic [ATAN_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
    logic [ATAN_W-1:0] val;
    case (idx)
      5'd0:    val = 22'd2949120;
      5'd1:    val = 22'd1740967;
      5'd2:    val = 22'd919879;
      5'd3:    val = 22'd466945;
      5'd4:    val = 22'd234379;
      5'd5:    val = 22'd117304;
      5'd6:    val = 22'd58666;
      5'd7:    val = 22'd29335;
      5'd8:    val = 22'd14668;
      5'd9:    val = 22'd7334;
      5'd10:   val = 22'd3667;
      5'd11:   val = 22'd1833;
      5'd12:   val = 22'd917;
      5'd13:   val = 22'd458;
      5'd14:   val = 22'd229;
      5'd15:   val = 22'd115;
      5'd16:   val = 22'd57;
      5'd17:   val = 22'd29;
      5'd18:   val = 22'd14;
      5'd19:   val = 22'd7;
      5'd20:   val = 22'd4;
      5'd21:   val = 22'd2;
      5'd22:   val = 22'd1;
      default: val = 22'd0;
    endcase
    return val;
  endfunction

endpackage

// ===== rtl/mhc_in_if.sv =====
// ----------------------------------------------------------------------------
// mhc_in_if
// sample request channel: op code and three raw axis words
// ----------------------------------------------------------------------------
interface mhc_in_if;
  logic                          valid;
  logic                          ready;
  logic [mhc_pkg::OP_W-1:0]      op;
  logic [mhc_pkg::AXIS_W-1:0]    x_word;
  logic [mhc_pkg::AXIS_W-1:0]    z_word;
  logic [mhc_pkg::AXIS_W-1:0]    y_word;

  modport source (output valid, output op, output x_word, output z_word,
                  output y_word, input ready);
  modport sink   (input valid, input op, input x_word, input z_word,
                  input y_word, output ready);
endinterface

// ===== rtl/mhc_out_if.sv =====
// ----------------------------------------------------------------------------
// mhc_out_if
// result channel: signed axes, heading and calibration flags
// ----------------------------------------------------------------------------
interface mhc_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [mhc_pkg::AXIS_W-1:0]  x_value;
  logic signed [mhc_pkg::AXIS_W-1:0]  y_value;
  logic signed [mhc_pkg::AXIS_W-1:0]  z_value;
  logic [mhc_pkg::HEADING_W-1:0]      heading;
  logic                               calibrating;
  logic                               cal_done;

  modport source (output valid, output x_value, output y_value, output z_value,
                  output heading, output calibrating, output cal_done,
                  input ready);
  modport sink   (input valid, input x_value, input y_value, input z_value,
                  input heading, input calibrating, input cal_done,
                  output ready);
endinterface

// ===== rtl/mhc_cfg_if.sv =====
// ----------------------------------------------------------------------------
// mhc_cfg_if
// register write channel: register index and write data
// ----------------------------------------------------------------------------
interface mhc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [mhc_pkg::CFG_IDX_W-1:0]    index;
  logic [mhc_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/magnetometer_heading_calibration.sv =====
// ----------------------------------------------------------------------------
// magnetometer heading calibration
// hard-iron calibration per axis and compass heading from an iterative cordic
// ----------------------------------------------------------------------------
// in_chan carries one request: an op code (measure, start calibration,
// calibration sample) and raw X, Z, Y words read as two's complement.
// out_chan gives exactly one result per request: the signed axes, the
// heading in degrees plus 180 with ANGLE_FRAC_BITS fraction bits, and the
// calibrating / cal_done flags. cfg_chan writes cal_samples (index 0) and
// span_threshold (index 1); it is always ready, other indexes are ignored.
// The cordic does one rotation step per cycle; a new request is taken only
// once the previous result has been loaded into the output register, since
// in_chan is ready only while the sequencer is idle.
// Three axis lanes track min/max side by side; the x and y offsets feed the
// heading cordic. Offsets update through the registered finish flag after the
// completing sample, while its own heading still uses the old ones.
// A result waits in the output register while the receiver stalls; the next
// request is still taken and held in the cordic until the register frees.
// Synchronous reset restores cal_samples 200, span_threshold 25, clears all
// trackers, offsets and the sample count, and empties the output register.
// ----------------------------------------------------------------------------
`include "magnetometer_heading_calibration_macros.svh"

module magnetometer_heading_calibration #(
  parameter int ANGLE_FRAC_BITS = mhc_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STEPS    = mhc_pkg::CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  mhc_in_if.sink      in_chan,
  mhc_out_if.source   out_chan,
  mhc_cfg_if.sink     cfg_chan
);

  localparam logic [mhc_pkg::HEADING_W-1:0] HEADING_MAX =
    mhc_pkg::HEADING_W'(360 * (1 << ANGLE_FRAC_BITS));

  // control state
  mhc_pkg::state_t                  state_r, state_nxt;
  logic [mhc_pkg::COUNT_W-1:0]      cal_samples_r, cal_samples_nxt;
  logic [mhc_pkg::AXIS_W-1:0]       span_thr_r, span_thr_nxt;
  logic [mhc_pkg::COUNT_W-1:0]      sample_count_r, sample_count_nxt;
  logic                             cal_active_r, cal_active_nxt;
  logic                             fin_r, fin_nxt;
  logic                             out_valid_r, out_valid_nxt;

  // request and result payload
  logic signed [mhc_pkg::AXIS_W-1:0] item_x_r, item_y_r, item_z_r;
  logic                              item_cal_r, item_done_r;
  logic signed [mhc_pkg::AXIS_W-1:0] out_x_r, out_y_r, out_z_r;
  logic [mhc_pkg::HEADING_W-1:0]     out_heading_r;
  logic                              out_cal_r, out_done_r;

  logic                              in_acc, cfg_acc, out_free, load;
  logic                              is_start, track_en, finish;
  logic [mhc_pkg::COUNT_W-1:0]       count_inc;
  logic signed [mhc_pkg::AXIS_W-1:0] x_s, y_s, z_s;
  logic signed [mhc_pkg::AXIS_W-1:0] off_x, off_y;
  logic signed [mhc_pkg::DIFF_W-1:0] dx, dy;
  logic                              cordic_done;
  logic [mhc_pkg::HEADING_W-1:0]     heading;
  mhc_pkg::lane_ctrl_t               lane_ctrl;

  // handshakes
  assign in_chan.ready  = (state_r == mhc_pkg::ST_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign in_acc   = in_chan.valid && in_chan.ready;
  assign cfg_acc  = cfg_chan.valid && cfg_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;

  // raw words read as two's complement
  assign x_s = $signed(in_chan.x_word);
  assign y_s = $signed(in_chan.y_word);
  assign z_s = $signed(in_chan.z_word);

  // request decode; reserved op code behaves like measure
  assign is_start  = (in_chan.op == mhc_pkg::OP_START);
  assign track_en  = (in_chan.op == mhc_pkg::OP_SAMPLE) && cal_active_r;
  assign count_inc = sample_count_r + mhc_pkg::COUNT_W'(1);
  // a count wrapping to zero also ends the run; zero cal_samples acts as one
  assign finish    = track_en &&
                     ((count_inc >= cal_samples_r) || (count_inc == '0));

  // start requests see cleared offsets
  assign dx = is_start ? mhc_pkg::DIFF_W'(x_s)
                       : mhc_pkg::DIFF_W'(x_s) - mhc_pkg::DIFF_W'(off_x);
  assign dy = is_start ? mhc_pkg::DIFF_W'(y_s)
                       : mhc_pkg::DIFF_W'(y_s) - mhc_pkg::DIFF_W'(off_y);

  // lanes track on the accept edge and take offsets in the following cycle
  assign lane_ctrl.clear  = in_acc && is_start;
  assign lane_ctrl.track  = in_acc && track_en;
  assign lane_ctrl.finish = fin_r;

  mhc_axis_lane u_lane_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (lane_ctrl),
    .sample    (x_s),
    .threshold (span_thr_r),
    .offset    (off_x)
  );

  mhc_axis_lane u_lane_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (lane_ctrl),
    .sample    (y_s),
    .threshold (span_thr_r),
    .offset    (off_y)
  );

  // z offset is kept but never enters the heading
  mhc_axis_lane u_lane_z (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (lane_ctrl),
    .sample    (z_s),
    .threshold (span_thr_r),
    .offset    ()
  );

  mhc_cordic #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .CORDIC_STEPS    (CORDIC_STEPS)
  ) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (in_acc),
    .dx      (dx),
    .dy      (dy),
    .done    (cordic_done),
    .heading (heading)
  );

  // sequencer: idle until a request, busy until the result is loaded into the output register
  always_comb begin
    state_nxt = state_r;
    load      = 1'b0;
    case (state_r)
      mhc_pkg::ST_IDLE: begin
        if (in_acc) state_nxt = mhc_pkg::ST_BUSY;
      end
      mhc_pkg::ST_BUSY: begin
        if (cordic_done && out_free) begin
          load      = 1'b1;
          state_nxt = mhc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mhc_pkg::ST_IDLE;
    endcase
  end

  // calibration run bookkeeping and register writes
  always_comb begin
    sample_count_nxt = sample_count_r;
    cal_active_nxt   = cal_active_r;
    fin_nxt          = in_acc && finish;
    cal_samples_nxt  = cal_samples_r;
    span_thr_nxt     = span_thr_r;
    if (in_acc) begin
      if (is_start) begin
        sample_count_nxt = '0;
        cal_active_nxt   = 1'b1;
      end else if (track_en) begin
        sample_count_nxt = count_inc;
        if (finish) cal_active_nxt = 1'b0;
      end
    end
    if (cfg_acc) begin
      if (cfg_chan.index == mhc_pkg::REG_CAL_SAMPLES) begin
        cal_samples_nxt = cfg_chan.data[mhc_pkg::COUNT_W-1:0];
      end else if (cfg_chan.index == mhc_pkg::REG_SPAN_THR) begin
        span_thr_nxt = cfg_chan.data[mhc_pkg::AXIS_W-1:0];
      end
    end
  end

  // output register empties on take, refills on load
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= mhc_pkg::ST_IDLE;
      cal_samples_r  <= mhc_pkg::CAL_SAMPLES_RST;
      span_thr_r     <= mhc_pkg::SPAN_THR_RST;
      sample_count_r <= '0;
      cal_active_r   <= 1'b0;
      fin_r          <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      cal_samples_r  <= cal_samples_nxt;
      span_thr_r     <= span_thr_nxt;
      sample_count_r <= sample_count_nxt;
      cal_active_r   <= cal_active_nxt;
      fin_r          <= fin_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // request payload captured on accept, result payload on load
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_x_r    <= x_s;
      item_y_r    <= y_s;
      item_z_r    <= z_s;
      item_cal_r  <= cal_active_nxt;
      item_done_r <= finish;
    end
    if (load) begin
      out_x_r       <= item_x_r;
      out_y_r       <= item_y_r;
      out_z_r       <= item_z_r;
      out_heading_r <= heading;
      out_cal_r     <= item_cal_r;
      out_done_r    <= item_done_r;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.x_value     = out_x_r;
  assign out_chan.y_value     = out_y_r;
  assign out_chan.z_value     = out_z_r;
  assign out_chan.heading     = out_heading_r;
  assign out_chan.calibrating = out_cal_r;
  assign out_chan.cal_done    = out_done_r;

  // a completing sample always closes the run
  `MHC_ASSERT(a_done_ends_run, out_valid_r && out_done_r |-> !out_cal_r)
  // a start request opens a fresh run
  `MHC_ASSERT(a_start_opens_run, in_acc && is_start |=> cal_active_r && (sample_count_r == '0))
  // heading never leaves the full circle
  `MHC_ASSERT(a_heading_range, out_valid_r |-> out_heading_r <= HEADING_MAX)
  // reset leaves the block empty and idle
  `MHC_ASSERT_RST(a_reset_quiet, !rst_n |=> !out_valid_r && (state_r == mhc_pkg::ST_IDLE))

endmodule

// ===== rtl/mhc_axis_lane.sv =====
// ----------------------------------------------------------------------------
// mhc_axis_lane
// one axis: min/max tracker and hard-iron offset from the tracked span
// ----------------------------------------------------------------------------
module mhc_axis_lane (
  input  logic                               clk,
  input  logic                               rst_n,
  input  mhc_pkg::lane_ctrl_t                ctrl,
  input  logic signed [mhc_pkg::AXIS_W-1:0]  sample,
  input  logic [mhc_pkg::AXIS_W-1:0]         threshold,
  output logic signed [mhc_pkg::AXIS_W-1:0]  offset
);

  logic signed [mhc_pkg::AXIS_W-1:0] min_r, min_nxt;
  logic signed [mhc_pkg::AXIS_W-1:0] max_r, max_nxt;
  logic signed [mhc_pkg::AXIS_W-1:0] offset_r, offset_nxt;
  logic signed [mhc_pkg::DIFF_W-1:0] span;
  logic signed [mhc_pkg::DIFF_W-1:0] sum;
  logic signed [mhc_pkg::DIFF_W-1:0] sum_adj;
  logic signed [mhc_pkg::DIFF_W-1:0] avg;

  // span is never negative since both trackers start at zero
  assign span    = mhc_pkg::DIFF_W'(max_r) - mhc_pkg::DIFF_W'(min_r);
  assign sum     = mhc_pkg::DIFF_W'(max_r) + mhc_pkg::DIFF_W'(min_r);
  // round toward zero on odd negative sums
  assign sum_adj = sum + mhc_pkg::DIFF_W'({1'b0, sum[mhc_pkg::DIFF_W-1]});
  assign avg     = sum_adj >>> 1;

  always_comb begin
    min_nxt    = min_r;
    max_nxt    = max_r;
    offset_nxt = offset_r;
    if (ctrl.clear) begin
      min_nxt    = '0;
      max_nxt    = '0;
      offset_nxt = '0;
    end else if (ctrl.track) begin
      if (sample > max_r) max_nxt = sample;
      if (sample < min_r) min_nxt = sample;
    end else if (ctrl.finish) begin
      if (span > $signed({1'b0, threshold})) begin
        offset_nxt = avg[mhc_pkg::AXIS_W-1:0];
      end else begin
        offset_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r    <= '0;
      max_r    <= '0;
      offset_r <= '0;
    end else begin
      min_r    <= min_nxt;
      max_r    <= max_nxt;
      offset_r <= offset_nxt;
    end
  end

  assign offset = offset_r;

endmodule

// ===== rtl/mhc_cordic.sv =====
// ----------------------------------------------------------------------------
// mhc_cordic
// iterative vectoring cordic, one rotation step per cycle, gives the heading
// ----------------------------------------------------------------------------
module mhc_cordic #(
  parameter int ANGLE_FRAC_BITS = mhc_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STEPS    = mhc_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [mhc_pkg::DIFF_W-1:0]   dx,
  input  logic signed [mhc_pkg::DIFF_W-1:0]   dy,
  output logic                                done,
  output logic [mhc_pkg::HEADING_W-1:0]       heading
);

  localparam int XW    = mhc_pkg::CORDIC_XW;
  localparam int ZW    = mhc_pkg::CORDIC_ZW;
  localparam int CNT_W = $clog2(CORDIC_STEPS + 1);
  localparam int SHIFT = mhc_pkg::DEG_BITS - ANGLE_FRAC_BITS;
  localparam logic signed [ZW-1:0] Z_HALF = ZW'(180 * (1 << mhc_pkg::DEG_BITS));
  localparam logic signed [ZW-1:0] Z_FULL = ZW'(360 * (1 << mhc_pkg::DEG_BITS));
  localparam logic [ZW-1:0] RND = ZW'(1) << (SHIFT - 1);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(CORDIC_STEPS);

  logic signed [XW-1:0] x_r, x_nxt;
  logic signed [XW-1:0] y_r, y_nxt;
  logic signed [ZW-1:0] z_r, z_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 zero_r, zero_nxt;

  logic signed [XW-1:0] x0, y0;
  logic signed [XW-1:0] xs, ys;
  logic signed [ZW-1:0] ang;
  logic signed [ZW-1:0] z_fin, total, clamped;
  logic [ZW-1:0]        rnd, scaled;

  assign x0  = XW'(dx) <<< mhc_pkg::PRESCALE_BITS;
  assign y0  = XW'(dy) <<< mhc_pkg::PRESCALE_BITS;
  assign xs  = x_r >>> cnt_r;
  assign ys  = y_r >>> cnt_r;
  assign ang = ZW'(mhc_pkg::atan_q16(mhc_pkg::ATAN_IDX_W'(cnt_r)));
  assign done = (cnt_r == LAST);

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    cnt_nxt  = cnt_r;
    zero_nxt = zero_r;
    if (start) begin
      cnt_nxt  = '0;
      zero_nxt = (dx == '0) && (dy == '0);
      if (dx < 0) begin
        // turn into the right half plane first
        x_nxt = -x0;
        y_nxt = -y0;
        z_nxt = (dy >= 0) ? Z_HALF : -Z_HALF;
      end else begin
        x_nxt = x0;
        y_nxt = y0;
        z_nxt = '0;
      end
    end else if (!done) begin
      cnt_nxt = cnt_r + CNT_W'(1);
      if (y_r > 0) begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + ang;
      end else begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - ang;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= LAST;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    zero_r <= zero_nxt;
  end

  // a zero vector gives angle zero
  assign z_fin = zero_r ? '0 : z_r;
  assign total = z_fin + Z_HALF;

  always_comb begin
    if (total < 0) begin
      clamped = '0;
    end else if (total > Z_FULL) begin
      clamped = Z_FULL;
    end else begin
      clamped = total;
    end
  end

  assign rnd     = $unsigned(clamped) + RND;
  assign scaled  = rnd >> SHIFT;
  assign heading = scaled[mhc_pkg::HEADING_W-1:0];

endmodule
